// ===== hw/rtl/psn_pkg.sv =====
// shared constants and types for the polyline segment normal block
`timescale 1ns / 1ps
package psn_pkg;

    localparam int CW   = 24;          // coordinate width, signed q15.8
    localparam int DW   = CW + 1;      // difference width
    localparam int NFB  = 14;          // normal fraction bits
    localparam int NW   = 16;          // normal output width
    localparam int SW   = 16;          // normal_scale width, unsigned q8.8
    localparam int MW   = 31;          // normalised magnitude width, msb lands in bit 30
    localparam int LW   = 32;          // segment length width
    localparam int SQW  = 64;          // squared sum and root working width
    localparam int QW   = NFB + 1;     // quotient width, up to 2^nfb
    localparam int NUMW = MW + NFB + 1; // dividend width
    localparam int TW   = CW + 2;      // tip sum width
    localparam int CNTW = 5;           // iteration counter width

    localparam logic [SW-1:0] SCALE_RESET = SW'(2560);

    typedef enum logic [0:0] {
        REG_LEFT_NORMAL  = 1'b0,
        REG_NORMAL_SCALE = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic signed [DW-1:0] dx;
        logic signed [DW-1:0] dy;
        logic signed [CW-1:0] mx;
        logic signed [CW-1:0] my;
    } cmd_t;

endpackage

// ===== hw/rtl/psn_front.sv =====
// input side: keeps the previous vertex, forms differences and midpoints
`timescale 1ns / 1ps
module psn_front
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [2*psn_pkg::CW-1:0]    s_tdata,
    input  logic                        s_tuser,
    input  logic                        q_full,
    output logic                        push,
    output psn_pkg::cmd_t               push_cmd
);
    import psn_pkg::*;

    logic signed [CW-1:0] prev_x_reg, prev_x_next;
    logic signed [CW-1:0] prev_y_reg, prev_y_next;
    logic                 have_prev_reg, have_prev_next;
    logic signed [CW-1:0] cur_x, cur_y;
    logic signed [DW-1:0] sum_x, sum_y;
    logic                 accept;

    assign cur_x    = s_tdata[CW-1:0];
    assign cur_y    = s_tdata[2*CW-1:CW];
    assign s_tready = ~q_full;
    assign accept   = s_tvalid & ~q_full;
    assign push     = accept & have_prev_reg & ~s_tuser;

    assign sum_x = {prev_x_reg[CW-1], prev_x_reg} + {cur_x[CW-1], cur_x};
    assign sum_y = {prev_y_reg[CW-1], prev_y_reg} + {cur_y[CW-1], cur_y};

    always_comb
    begin
        push_cmd.dx = {prev_x_reg[CW-1], prev_x_reg} - {cur_x[CW-1], cur_x};
        push_cmd.dy = {prev_y_reg[CW-1], prev_y_reg} - {cur_y[CW-1], cur_y};
        // arithmetic halving floors
        push_cmd.mx = sum_x[CW:1];
        push_cmd.my = sum_y[CW:1];
    end

    always_comb
    begin
        prev_x_next    = prev_x_reg;
        prev_y_next    = prev_y_reg;
        have_prev_next = have_prev_reg;
        if (accept)
        begin
            prev_x_next    = cur_x;
            prev_y_next    = cur_y;
            have_prev_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            have_prev_reg <= 1'b0;
        end
        else
        begin
            prev_x_reg    <= prev_x_next;
            prev_y_reg    <= prev_y_next;
            have_prev_reg <= have_prev_next;
        end
    end

endmodule

// ===== hw/rtl/psn_queue.sv =====
// two-entry command queue between front and back
`timescale 1ns / 1ps
module psn_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  psn_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          not_empty,
    output psn_pkg::cmd_t head_cmd
);
    import psn_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full      = count_reg[1];
    assign not_empty = (count_reg != 2'd0);
    assign head_cmd  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hw/rtl/psn_back.sv =====
// back end: normalise, square root, divide, scale and clamp on shared units
`timescale 1ns / 1ps
module psn_back
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_valid,
    output logic                        pop,
    input  psn_pkg::cmd_t               cmd,
    input  logic                        left_normal,
    input  logic [psn_pkg::SW-1:0]      normal_scale,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [psn_pkg::NW-1:0]      normal_x,
    output logic [psn_pkg::NW-1:0]      normal_y,
    output logic [psn_pkg::CW-1:0]      mid_x,
    output logic [psn_pkg::CW-1:0]      mid_y,
    output logic [psn_pkg::CW-1:0]      tip_x,
    output logic [psn_pkg::CW-1:0]      tip_y,
    output logic                        zero_length,
    output logic                        saturated
);
    import psn_pkg::*;

    typedef enum logic [10:0] {
        ST_IDLE = 11'b00000000001,
        ST_NORM = 11'b00000000010,
        ST_SQA  = 11'b00000000100,
        ST_SQB  = 11'b00000001000,
        ST_SQC  = 11'b00000010000,
        ST_ROOT = 11'b00000100000,
        ST_DPRE = 11'b00001000000,
        ST_DIV  = 11'b00010000000,
        ST_SCL1 = 11'b00100000000,
        ST_SCL2 = 11'b01000000000,
        ST_SCL3 = 11'b10000000000
    } state_t;

    localparam logic signed [TW-1:0] TIP_MAX = {{(TW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [TW-1:0] TIP_MIN = {{(TW-CW+1){1'b1}}, {(CW-1){1'b0}}};

    state_t              state_reg, state_next;
    logic [MW-1:0]       ax_reg, ax_next, ay_reg, ay_next;
    logic                dxneg_reg, dxneg_next, dyneg_reg, dyneg_next;
    logic                zero_reg, zero_next;
    logic [CW-1:0]       mx_reg, mx_next, my_reg, my_next;
    logic [2*MW-1:0]     prod_reg, prod_next;
    logic [SQW-1:0]      s_reg, s_next, r_reg, r_next, bit_reg, bit_next;
    logic [LW-1:0]       rem_reg, rem_next;
    logic [QW-1:0]       numlo_reg, numlo_next, q_reg, q_next;
    logic [QW-1:0]       qx_reg, qx_next, qy_reg, qy_next;
    logic [CNTW-1:0]     cnt_reg, cnt_next;
    logic                divy_reg, divy_next;
    logic [CW-1:0]       tx_reg, tx_next;
    logic                satx_reg, satx_next;
    logic                out_valid_reg, out_valid_next;
    logic [NW-1:0]       nx_out_reg, nx_out_next, ny_out_reg, ny_out_next;
    logic [CW-1:0]       mx_out_reg, mx_out_next, my_out_reg, my_out_next;
    logic [CW-1:0]       tx_out_reg, tx_out_next, ty_out_reg, ty_out_next;
    logic                zl_out_reg, zl_out_next, sat_out_reg, sat_out_next;

    logic [MW-1:0]       mul_a, mul_b;
    logic [2*MW-1:0]     mul_p;
    logic [DW-1:0]       adx, ady;
    logic [SQW-1:0]      root_trial;
    logic [LW-1:0]       len;
    logic [MW-1:0]       div_a;
    logic [NUMW-1:0]     num;
    logic [LW:0]         rem_shift;
    logic                q_bit;
    logic                nx_neg, ny_neg;
    logic [2*MW-1:0]     rnd_sum;
    logic [SW:0]         r_mag;
    logic                tip_neg;
    logic [CW-1:0]       tip_mid;
    logic signed [TW-1:0] tip_sum;
    logic [CW-1:0]       tip_val;
    logic                tip_sat;
    logic                out_free;

    assign mul_p = mul_a * mul_b;
    assign adx   = cmd.dx[DW-1] ? -cmd.dx : cmd.dx;
    assign ady   = cmd.dy[DW-1] ? -cmd.dy : cmd.dy;
    assign len   = r_reg[LW-1:0];
    assign root_trial = r_reg + bit_reg;
    assign div_a = divy_reg ? ay_reg : ax_reg;
    assign num   = NUMW'({div_a, {NFB{1'b0}}}) + NUMW'(len[LW-1:1]);
    assign rem_shift = {rem_reg, numlo_reg[QW-1]};
    assign q_bit = (rem_shift >= {1'b0, len});

    // signs after the quarter turn
    assign nx_neg = left_normal ? ~dyneg_reg : dyneg_reg;
    assign ny_neg = left_normal ? dxneg_reg : ~dxneg_reg;

    // scaled offset, half away from zero, then clamp
    assign rnd_sum = prod_reg + (2*MW)'(1 << (NFB - 1));
    assign r_mag   = rnd_sum[NFB+SW:NFB];
    assign tip_neg = state_reg == ST_SCL2 ? nx_neg : ny_neg;
    assign tip_mid = state_reg == ST_SCL2 ? mx_reg : my_reg;
    assign tip_sum = tip_neg
                   ? $signed({{(TW-CW){tip_mid[CW-1]}}, tip_mid}) - $signed(TW'(r_mag))
                   : $signed({{(TW-CW){tip_mid[CW-1]}}, tip_mid}) + $signed(TW'(r_mag));

    always_comb
    begin
        tip_sat = 1'b0;
        tip_val = tip_sum[CW-1:0];
        if (tip_sum > TIP_MAX)
        begin
            tip_sat = 1'b1;
            tip_val = TIP_MAX[CW-1:0];
        end
        else if (tip_sum < TIP_MIN)
        begin
            tip_sat = 1'b1;
            tip_val = TIP_MIN[CW-1:0];
        end
    end

    assign out_free = ~out_valid_reg | out_ready;
    assign pop      = (state_reg == ST_IDLE) & q_valid;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_SQA:
            begin
                mul_a = ax_reg;
                mul_b = ax_reg;
            end
            ST_SQB:
            begin
                mul_a = ay_reg;
                mul_b = ay_reg;
            end
            ST_SCL1:
            begin
                mul_a = MW'(qy_reg);
                mul_b = MW'(normal_scale);
            end
            ST_SCL2:
            begin
                mul_a = MW'(qx_reg);
                mul_b = MW'(normal_scale);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        ax_next        = ax_reg;
        ay_next        = ay_reg;
        dxneg_next     = dxneg_reg;
        dyneg_next     = dyneg_reg;
        zero_next      = zero_reg;
        mx_next        = mx_reg;
        my_next        = my_reg;
        prod_next      = prod_reg;
        s_next         = s_reg;
        r_next         = r_reg;
        bit_next       = bit_reg;
        rem_next       = rem_reg;
        numlo_next     = numlo_reg;
        q_next         = q_reg;
        qx_next        = qx_reg;
        qy_next        = qy_reg;
        cnt_next       = cnt_reg;
        divy_next      = divy_reg;
        tx_next        = tx_reg;
        satx_next      = satx_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        nx_out_next    = nx_out_reg;
        ny_out_next    = ny_out_reg;
        mx_out_next    = mx_out_reg;
        my_out_next    = my_out_reg;
        tx_out_next    = tx_out_reg;
        ty_out_next    = ty_out_reg;
        zl_out_next    = zl_out_reg;
        sat_out_next   = sat_out_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    ax_next    = MW'(adx);
                    ay_next    = MW'(ady);
                    dxneg_next = cmd.dx[DW-1];
                    dyneg_next = cmd.dy[DW-1];
                    mx_next    = cmd.mx;
                    my_next    = cmd.my;
                    zero_next  = (adx == '0) && (ady == '0);
                    qx_next    = '0;
                    qy_next    = '0;
                    if ((adx == '0) && (ady == '0))
                        state_next = ST_SCL1;
                    else
                        state_next = ST_NORM;
                end
            end
            ST_NORM:
            begin
                // shift up until the larger magnitude reaches bit 30
                if (ax_reg[MW-1] | ay_reg[MW-1])
                    state_next = ST_SQA;
                else
                begin
                    ax_next = {ax_reg[MW-2:0], 1'b0};
                    ay_next = {ay_reg[MW-2:0], 1'b0};
                end
            end
            ST_SQA:
            begin
                prod_next  = mul_p;
                state_next = ST_SQB;
            end
            ST_SQB:
            begin
                s_next     = SQW'(prod_reg);
                prod_next  = mul_p;
                state_next = ST_SQC;
            end
            ST_SQC:
            begin
                s_next     = s_reg + SQW'(prod_reg);
                r_next     = '0;
                bit_next   = SQW'(1) << (SQW - 2);
                cnt_next   = '0;
                state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                if (s_reg >= root_trial)
                begin
                    s_next = s_reg - root_trial;
                    r_next = (r_reg >> 1) + bit_reg;
                end
                else
                    r_next = r_reg >> 1;
                bit_next = bit_reg >> 2;
                cnt_next = cnt_reg + CNTW'(1);
                if (cnt_reg == CNTW'(SQW / 2 - 1))
                begin
                    divy_next  = 1'b0;
                    state_next = ST_DPRE;
                end
            end
            ST_DPRE:
            begin
                rem_next   = LW'(num[NUMW-1:QW]);
                numlo_next = num[QW-1:0];
                q_next     = '0;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (q_bit)
                    rem_next = LW'(rem_shift - {1'b0, len});
                else
                    rem_next = rem_shift[LW-1:0];
                numlo_next = {numlo_reg[QW-2:0], 1'b0};
                q_next     = {q_reg[QW-2:0], q_bit};
                cnt_next   = cnt_reg + CNTW'(1);
                if (cnt_reg == CNTW'(QW - 1))
                begin
                    if (divy_reg)
                    begin
                        qy_next    = {q_reg[QW-2:0], q_bit};
                        state_next = ST_SCL1;
                    end
                    else
                    begin
                        qx_next    = {q_reg[QW-2:0], q_bit};
                        divy_next  = 1'b1;
                        state_next = ST_DPRE;
                    end
                end
            end
            ST_SCL1:
            begin
                // normal x magnitude is the y quotient
                prod_next  = mul_p;
                state_next = ST_SCL2;
            end
            ST_SCL2:
            begin
                tx_next    = tip_val;
                satx_next  = tip_sat;
                prod_next  = mul_p;
                state_next = ST_SCL3;
            end
            ST_SCL3:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    nx_out_next    = nx_neg ? -NW'(qy_reg) : NW'(qy_reg);
                    ny_out_next    = ny_neg ? -NW'(qx_reg) : NW'(qx_reg);
                    mx_out_next    = mx_reg;
                    my_out_next    = my_reg;
                    tx_out_next    = tx_reg;
                    ty_out_next    = tip_val;
                    zl_out_next    = zero_reg;
                    sat_out_next   = satx_reg | tip_sat;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        ax_reg     <= ax_next;
        ay_reg     <= ay_next;
        dxneg_reg  <= dxneg_next;
        dyneg_reg  <= dyneg_next;
        zero_reg   <= zero_next;
        mx_reg     <= mx_next;
        my_reg     <= my_next;
        prod_reg   <= prod_next;
        s_reg      <= s_next;
        r_reg      <= r_next;
        bit_reg    <= bit_next;
        rem_reg    <= rem_next;
        numlo_reg  <= numlo_next;
        q_reg      <= q_next;
        qx_reg     <= qx_next;
        qy_reg     <= qy_next;
        divy_reg   <= divy_next;
        tx_reg     <= tx_next;
        satx_reg   <= satx_next;
        nx_out_reg <= nx_out_next;
        ny_out_reg <= ny_out_next;
        mx_out_reg <= mx_out_next;
        my_out_reg <= my_out_next;
        tx_out_reg <= tx_out_next;
        ty_out_reg <= ty_out_next;
        zl_out_reg <= zl_out_next;
        sat_out_reg <= sat_out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign normal_x    = nx_out_reg;
    assign normal_y    = ny_out_reg;
    assign mid_x       = mx_out_reg;
    assign mid_y       = my_out_reg;
    assign tip_x       = tx_out_reg;
    assign tip_y       = ty_out_reg;
    assign zero_length = zl_out_reg;
    assign saturated   = sat_out_reg;

endmodule

// ===== hw/rtl/polyline_segment_normals_core.sv =====
// top level: apb registers, front end, command queue and arithmetic back end
// back end steps: 7 to 30 normalising shifts, a 32-step
//   root and two 15-step divides; a zero-length segment goes straight to scaling
// flow: the back end handles one segment at a time and takes the next once a result is
//   registered; the front takes vertices while the queue has room, first ones give no result
// reset: asynchronous active low rst_n clears vertex, queue, sequencer, valid; regs 0, 10.0
`timescale 1ns / 1ps
module polyline_segment_normals_core
(
    input  logic         clk,
    input  logic         rst_n,
    // apb configuration port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    // vertex input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [47:0]  s_tdata,   // point_x [23:0], point_y [47:24]
    input  logic         s_tuser,   // first_point
    // segment result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // normal_x, normal_y, mid_x, mid_y, tip_x, tip_y
    output logic [1:0]   m_tuser    // zero_length, saturated
);
    import psn_pkg::*;

    // configuration registers
    logic          left_normal_reg, left_normal_next;
    logic [SW-1:0] normal_scale_reg, normal_scale_next;
    logic          cfg_write;
    reg_idx_t      cfg_idx;

    // front to queue and queue to back
    logic          q_push, q_full, q_pop, q_not_empty;
    cmd_t          push_cmd, head_cmd;

    // result fields
    logic [NW-1:0] normal_x, normal_y;
    logic [CW-1:0] mid_x, mid_y, tip_x, tip_y;
    logic          zero_length, saturated;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;
    assign cfg_idx   = reg_idx_t'(paddr[2]);

    always_comb
    begin
        left_normal_next  = left_normal_reg;
        normal_scale_next = normal_scale_reg;
        if (cfg_write)
        begin
            case (cfg_idx)
                REG_LEFT_NORMAL:  left_normal_next  = pwdata[0];
                REG_NORMAL_SCALE: normal_scale_next = pwdata[SW-1:0];
                default:          left_normal_next  = left_normal_reg;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_LEFT_NORMAL:  prdata = {31'd0, left_normal_reg};
            REG_NORMAL_SCALE: prdata = {{(32-SW){1'b0}}, normal_scale_reg};
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_normal_reg  <= 1'b0;
            normal_scale_reg <= SCALE_RESET;
        end
        else
        begin
            left_normal_reg  <= left_normal_next;
            normal_scale_reg <= normal_scale_next;
        end
    end

    // front end classifies vertices: first of a line only updates the previous vertex
    psn_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .push     (q_push),
        .push_cmd (push_cmd)
    );

    // short queue decouples the input transaction from the long back end
    psn_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_cmd  (head_cmd)
    );

    // back end holds its own output register so the next segment starts while a result waits
    psn_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_not_empty),
        .pop          (q_pop),
        .cmd          (head_cmd),
        .left_normal  (left_normal_reg),
        .normal_scale (normal_scale_reg),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .normal_x     (normal_x),
        .normal_y     (normal_y),
        .mid_x        (mid_x),
        .mid_y        (mid_y),
        .tip_x        (tip_x),
        .tip_y        (tip_y),
        .zero_length  (zero_length),
        .saturated    (saturated)
    );

    assign m_tdata = {tip_y, tip_x, mid_y, mid_x, normal_y, normal_x};
    assign m_tuser = {saturated, zero_length};

endmodule

// ===== tb/sv/polyline_segment_normals_core_test.sv =====
// self-checking testbench for the polyline segment normal block
`timescale 1ns / 1ps
module polyline_segment_normals_core_test;
    import psn_pkg::*;

    // result fields as they leave the block
    typedef struct {
        logic [15:0] nx;
        logic [15:0] ny;
        logic [23:0] mx;
        logic [23:0] my;
        logic [23:0] tx;
        logic [23:0] ty;
        logic        zero_len;
        logic        sat;
    } segment_t;

    // one row of the directed table: vertex, first flag, optional typed-in result
    typedef struct {
        logic [23:0] px;
        logic [23:0] py;
        logic        first;
        logic        typed;
        segment_t    want;
    } vertex_row_t;

    localparam int NUM_DIRECTED = 16;
    localparam int NUM_RANDOM   = 1350;

    logic         clk;
    logic         rst_n;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;
    logic         s_tvalid;
    logic         s_tready;
    logic [47:0]  s_tdata;   // point_x [23:0], point_y [47:24]
    logic         s_tuser;   // first_point
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;   // normal_x, normal_y, mid_x, mid_y, tip_x, tip_y
    logic [1:0]   m_tuser;   // zero_length, saturated

    // predictor copy of registers and previous vertex
    logic          turn_left;
    logic [15:0]   draw_scale;
    longint        last_x;
    longint        last_y;
    bit            last_valid;

    segment_t      pending_segments[$];
    int            mismatches;
    int            send_idle_pct;
    int            recv_stall_pct;
    vertex_row_t   vertex_table[NUM_DIRECTED];

    polyline_segment_normals_core u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #60ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic longint sign_ext24(logic [23:0] v);
        return longint'(signed'(v));
    endfunction

    function automatic longint abs_of(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // bitwise integer square root, floor
    function automatic longint unsigned floor_root(longint unsigned s);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > s)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (s >= root + bitv)
            begin
                s    -= root + bitv;
                root  = (root >> 1) + bitv;
            end
            else
                root >>= 1;
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic longint unit_component(longint unsigned a, longint unsigned len,
                                              bit neg);
        longint unsigned q;
        q = ((a << 14) + (len >> 1)) / len;
        if (q > (64'd1 << 14))
            q = 64'd1 << 14;
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint scaled_offset(longint n, logic [15:0] scale);
        longint unsigned r;
        r = (longint'(abs_of(n)) * longint'(scale) + (64'd1 << 13)) >> 14;
        return (n < 0) ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint clamp_coord(longint v, ref bit sat);
        if (v > 64'sd8388607)
        begin
            sat = 1'b1;
            return 64'sd8388607;
        end
        if (v < -64'sd8388608)
        begin
            sat = 1'b1;
            return -64'sd8388608;
        end
        return v;
    endfunction

    // works out the segment result for one vertex, queues it if there is one
    task automatic predict_segment(logic [23:0] px, logic [23:0] py, logic first);
        longint   cx, cy, dx, dy, ux, uy, nx, ny, sx, sy, tx, ty;
        longint unsigned ax, ay, big, len;
        bit       sat;
        segment_t seg;
        cx  = sign_ext24(px);
        cy  = sign_ext24(py);
        ux  = 0;
        uy  = 0;
        sat = 1'b0;
        if (first || !last_valid)
        begin
            last_x     = cx;
            last_y     = cy;
            last_valid = 1'b1;
            return;
        end
        dx  = last_x - cx;
        dy  = last_y - cy;
        ax  = abs_of(dx);
        ay  = abs_of(dy);
        big = (ax > ay) ? ax : ay;
        if (big != 0)
        begin
            while (big >= (64'd1 << 31))
            begin
                ax >>= 1;
                ay >>= 1;
                big >>= 1;
            end
            while (big < (64'd1 << 30))
            begin
                ax <<= 1;
                ay <<= 1;
                big <<= 1;
            end
            len = floor_root(ax * ax + ay * ay);
            ux  = unit_component(ax, len, dx < 0);
            uy  = unit_component(ay, len, dy < 0);
        end
        if (turn_left)
        begin
            nx = -uy;
            ny = ux;
        end
        else
        begin
            nx = uy;
            ny = -ux;
        end
        // arithmetic shift gives floor of the halved sum
        sx = (last_x + cx) >>> 1;
        sy = (last_y + cy) >>> 1;
        tx = clamp_coord(sx + scaled_offset(nx, draw_scale), sat);
        ty = clamp_coord(sy + scaled_offset(ny, draw_scale), sat);
        seg.nx       = nx[15:0];
        seg.ny       = ny[15:0];
        seg.mx       = sx[23:0];
        seg.my       = sy[23:0];
        seg.tx       = tx[23:0];
        seg.ty       = ty[23:0];
        seg.zero_len = (big == 0);
        seg.sat      = sat;
        pending_segments.insert(pending_segments.size(), seg);
        last_x = cx;
        last_y = cy;
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // apb write, setup then access phase
    task automatic write_register(reg_idx_t idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(4 * int'(idx));
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_LEFT_NORMAL)
            turn_left = value[0];
        else
            draw_scale = value[15:0];
        @(posedge clk);
    endtask

    // drive one vertex transaction and hold until it is taken
    task automatic send_vertex(logic [23:0] px, logic [23:0] py, logic first);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {py, px};
        s_tuser  <= first;
        predict_segment(px, py, first);
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // wait for every queued result, then let the back end drain
    task automatic drain_block();
        int guard;
        guard = 0;
        s_tvalid <= 1'b0;
        while (pending_segments.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (150) @(posedge clk);
    endtask

    // receiver: random stalls, checks every accepted result transaction
    initial
    begin
        segment_t want;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                if (pending_segments.size() == 0)
                    report_mismatch("unexpected result", m_tdata[23:0], 0);
                else
                begin
                    want = pending_segments.pop_front();
                    if (m_tdata[15:0] !== want.nx)
                        report_mismatch("normal_x", m_tdata[15:0], want.nx);
                    if (m_tdata[31:16] !== want.ny)
                        report_mismatch("normal_y", m_tdata[31:16], want.ny);
                    if (m_tdata[55:32] !== want.mx)
                        report_mismatch("mid_x", m_tdata[55:32], want.mx);
                    if (m_tdata[79:56] !== want.my)
                        report_mismatch("mid_y", m_tdata[79:56], want.my);
                    if (m_tdata[103:80] !== want.tx)
                        report_mismatch("tip_x", m_tdata[103:80], want.tx);
                    if (m_tdata[127:104] !== want.ty)
                        report_mismatch("tip_y", m_tdata[127:104], want.ty);
                    if (m_tuser[0] !== want.zero_len)
                        report_mismatch("zero_length", m_tuser[0], want.zero_len);
                    if (m_tuser[1] !== want.sat)
                        report_mismatch("saturated", m_tuser[1], want.sat);
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic segment_t seg_of(int nx, int ny, int mx, int my, int tx, int ty,
                                        bit z, bit s);
        segment_t r;
        r.nx = 16'(nx);
        r.ny = 16'(ny);
        r.mx = 24'(mx);
        r.my = 24'(my);
        r.tx = 24'(tx);
        r.ty = 24'(ty);
        r.zero_len = z;
        r.sat = s;
        return r;
    endfunction

    function automatic vertex_row_t row(int px, int py, bit first, bit typed, segment_t w);
        vertex_row_t r;
        r.px    = 24'(px);
        r.py    = 24'(py);
        r.first = first;
        r.typed = typed;
        r.want  = w;
        return r;
    endfunction

    // random coordinate, mostly small, sometimes at the extremes
    function automatic logic [23:0] rand_coord();
        case ($urandom_range(9))
            0:       return 24'h7FFFFF - 24'($urandom_range(3));
            1:       return 24'h800000 + 24'($urandom_range(3));
            2, 3:    return 24'($urandom);
            default: return 24'(int'($urandom_range(8191)) - 4096);
        endcase
    endfunction

    initial
    begin
        segment_t none;
        segment_t got;
        int phase;
        int line_len;
        logic [23:0] px, py;
        none       = seg_of(0, 0, 0, 0, 0, 0, 0, 0);
        mismatches = 0;
        turn_left  = 1'b0;
        draw_scale = SCALE_RESET;
        last_x     = 0;
        last_y     = 0;
        last_valid = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        rst_n    <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= 1'b0;

        // directed table; reset scale 10.0 and right turn apply to the first rows
        vertex_table[0]  = row(100, 100, 0, 0, none);          // no previous vertex
        vertex_table[1]  = row(100, 100, 0, 1,
                               seg_of(0, 0, 100, 100, 100, 100, 1, 0)); // zero length
        vertex_table[2]  = row(0, 100, 0, 1,                    // d = (100,0): n = (0,-1)
                               seg_of(0, -16384, 50, 100, 50, -2460, 0, 0));
        vertex_table[3]  = row(0, 0, 1, 0, none);               // new line
        vertex_table[4]  = row(0, 512, 0, 0, none);
        vertex_table[5]  = row(-5, -7, 0, 0, none);             // odd negative sum
        vertex_table[6]  = row(8388607, 8388607, 1, 0, none);
        vertex_table[7]  = row(-8388608, -8388608, 0, 0, none); // longest diagonal
        vertex_table[8]  = row(8388607, -8388608, 0, 0, none);
        vertex_table[9]  = row(8388607, 8388600, 1, 0, none);
        vertex_table[10] = row(8388607, 8388607, 0, 0, none);   // normal points inward, tip stays in range
        vertex_table[11] = row(-8388608, -8388600, 1, 0, none);
        vertex_table[12] = row(-8388608, -8388608, 0, 0, none); // normal points inward, tip stays in range
        vertex_table[13] = row(3, 1, 0, 0, none);
        vertex_table[14] = row(3, 1, 0, 0, none);                // zero length mid-line
        vertex_table[15] = row(-1, 2, 0, 0, none);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_DIRECTED; i++)
        begin
            if (vertex_table[i].typed)
            begin
                got = vertex_table[i].want;
                send_vertex(vertex_table[i].px, vertex_table[i].py, vertex_table[i].first);
                // typed-in value must agree with the predicted one on normal_x, tip_y and zero length
                if (pending_segments[$].nx !== got.nx || pending_segments[$].ty !== got.ty
                    || pending_segments[$].zero_len !== got.zero_len)
                    report_mismatch("directed row", i, 0);
            end
            else
                send_vertex(vertex_table[i].px, vertex_table[i].py, vertex_table[i].first);
        end
        drain_block();

        // phases walk through register settings and idling mixes
        for (phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: begin write_register(REG_LEFT_NORMAL, 32'h1);
                         write_register(REG_NORMAL_SCALE, 32'hFFFF); end
                1: begin write_register(REG_LEFT_NORMAL, 32'hFFFF_FFFE);
                         write_register(REG_NORMAL_SCALE, 32'h0); end
                2: begin write_register(REG_LEFT_NORMAL, 32'h1);
                         write_register(REG_NORMAL_SCALE, 32'h0001_0100); end
                3: write_register(REG_NORMAL_SCALE, 32'($urandom));
                4: write_register(REG_LEFT_NORMAL, 32'h0);
                default: write_register(REG_NORMAL_SCALE, 32'hAAAA_5555);
            endcase
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
                default: begin send_idle_pct = 13; recv_stall_pct = 13; end
            endcase
            for (int n = 0; n < NUM_RANDOM / 6; n += line_len)
            begin
                // mostly well-formed lines, occasionally a stray lone vertex
                line_len = $urandom_range(8, 1);
                for (int k = 0; k < line_len; k++)
                begin
                    px = rand_coord();
                    py = ($urandom_range(15) == 0) ? px : rand_coord();
                    if ($urandom_range(19) == 0 && k > 0)
                        send_vertex(px, py, 1'b0);  // repeat gives zero length
                    send_vertex(px, py, (k == 0) ? 1'b1 : ($urandom_range(30) == 0));
                end
                // hold off until the block has caught up, once per phase
                if (n == 0)
                begin
                    s_tvalid <= 1'b0;
                    @(posedge clk);
                    while (pending_segments.size() != 0)
                        @(posedge clk);
                end
            end
            drain_block();
        end

        if (mismatches == 0 && pending_segments.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
